// ===== rtl/nnd_pkg.sv =====
// ----------------------------------------------------------------------------
// nnd_pkg
// Types and fixed constants shared by the nearest-neighbour downscaler files.
// ----------------------------------------------------------------------------
package nnd_pkg;

    // Field widths fixed by the interface
    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 12;
    localparam int DIM_REG_W  = 13;
    localparam int STEP_W     = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd5;

    // Register values after reset
    localparam logic [DIM_REG_W-1:0] RST_SRC_WIDTH  = 13'd1920;
    localparam logic [DIM_REG_W-1:0] RST_SRC_HEIGHT = 13'd1080;
    localparam logic [DIM_REG_W-1:0] RST_DST_WIDTH  = 13'd720;
    localparam logic [DIM_REG_W-1:0] RST_DST_HEIGHT = 13'd480;
    localparam logic [STEP_W-1:0]    RST_X_STEP     = 29'd174763;
    localparam logic [STEP_W-1:0]    RST_Y_STEP     = 29'd147456;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CHAN_W-1:0] chan_a;
        logic [CHAN_W-1:0] chan_b;
        logic [CHAN_W-1:0] chan_c;
        logic              frame_start;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_a;
        logic [CHAN_W-1:0]  out_b;
        logic [CHAN_W-1:0]  out_c;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               frame_last;
    } t_out_word;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/nnd_front.sv =====
// ----------------------------------------------------------------------------
// nnd_front
// Register file, source/target counters and accumulators; picks the source
// pixels that map onto target pixels and pushes them into the queue.
// ----------------------------------------------------------------------------
module nnd_front #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nnd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nnd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    input  nnd_pkg::t_in_word             i_word,
    output logic                          o_stall,
    input  nnd_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output nnd_pkg::t_out_word            o_word
);
    import nnd_pkg::*;

    localparam int SC_W   = $clog2(MAX_DIM);
    localparam int TC_W   = $clog2(MAX_DIM + 1);
    localparam int CW     = SC_W + 1;
    localparam int ACC_W  = SC_W + FRAC_BITS;
    localparam int SUM_W  = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
    localparam int EW     = (DIM_REG_W > TC_W) ? DIM_REG_W : TC_W;
    localparam longint unsigned ACC_MAX_L  = (longint'(MAX_DIM) << FRAC_BITS) - 1;
    localparam longint unsigned FRAC_ONE_M1 = (longint'(1) << FRAC_BITS) - 1;

    function automatic logic [TC_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] v);
        logic [EW-1:0] w;
        begin
            w = EW'(v);
            if (v == '0) begin
                return TC_W'(1);
            end
            if (w > EW'(MAX_DIM)) begin
                return TC_W'(MAX_DIM);
            end
            return TC_W'(w);
        end
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [STEP_W-1:0] step);
        logic [SUM_W-1:0] s;
        begin
            s = SUM_W'(acc) + SUM_W'(step);
            if (s > SUM_W'(ACC_MAX_L)) begin
                return ACC_W'(ACC_MAX_L);
            end
            return ACC_W'(s);
        end
    endfunction

    // ceil of a Q.FRAC_BITS value
    function automatic logic [CW-1:0] ceil_q(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] s;
        begin
            s = {1'b0, acc} + (ACC_W + 1)'(FRAC_ONE_M1);
            return s[ACC_W:FRAC_BITS];
        end
    endfunction

    logic [DIM_REG_W-1:0] r_src_width, r_src_height, r_dst_width, r_dst_height;
    logic [STEP_W-1:0]    r_x_step, r_y_step;

    logic [SC_W-1:0]  r_src_col, r_src_row, n_src_col, n_src_row;
    logic [TC_W-1:0]  r_tgt_col, r_tgt_row, n_tgt_col, n_tgt_row;
    logic [ACC_W-1:0] r_col_acc, r_row_acc, n_col_acc, n_row_acc;

    logic [SC_W-1:0]  c_src_col, c_src_row;
    logic [TC_W-1:0]  c_tgt_col, c_tgt_row;
    logic [ACC_W-1:0] c_col_acc, c_row_acc;
    logic [TC_W-1:0]  sw, sh, dw, dh, sw_m1, sh_m1, dw_m1, dh_m1;
    logic             accept, row_sel, emit, col_end, row_end;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    assign sw    = eff_dim(r_src_width);
    assign sh    = eff_dim(r_src_height);
    assign dw    = eff_dim(r_dst_width);
    assign dh    = eff_dim(r_dst_height);
    assign sw_m1 = sw - TC_W'(1);
    assign sh_m1 = sh - TC_W'(1);
    assign dw_m1 = dw - TC_W'(1);
    assign dh_m1 = dh - TC_W'(1);

    // frame start clears the counters and accumulators before this pixel is classified
    assign c_src_col = i_word.frame_start ? '0 : r_src_col;
    assign c_src_row = i_word.frame_start ? '0 : r_src_row;
    assign c_tgt_col = i_word.frame_start ? '0 : r_tgt_col;
    assign c_tgt_row = i_word.frame_start ? '0 : r_tgt_row;
    assign c_col_acc = i_word.frame_start ? '0 : r_col_acc;
    assign c_row_acc = i_word.frame_start ? '0 : r_row_acc;

    assign row_sel = (c_tgt_row < dh) &&
                     ((ceil_q(c_row_acc) <= CW'(c_src_row)) || (CW'(sh_m1) <= CW'(c_src_row)));
    assign emit    = row_sel && (c_tgt_col < dw) &&
                     ((ceil_q(c_col_acc) <= CW'(c_src_col)) || (CW'(sw_m1) <= CW'(c_src_col)));
    assign col_end = CW'(c_src_col) >= CW'(sw_m1);
    assign row_end = CW'(c_src_row) >= CW'(sh_m1);

    assign o_push = accept && emit;

    always_comb begin
        o_word.out_a      = i_word.chan_a;
        o_word.out_b      = i_word.chan_b;
        o_word.out_c      = i_word.chan_c;
        o_word.out_col    = COORD_W'(c_tgt_col);
        o_word.out_row    = COORD_W'(c_tgt_row);
        o_word.frame_last = (c_tgt_col == dw_m1) && (c_tgt_row == dh_m1);
    end

    always_comb begin
        n_src_col = c_src_col;
        n_src_row = c_src_row;
        n_tgt_col = c_tgt_col;
        n_tgt_row = c_tgt_row;
        n_col_acc = c_col_acc;
        n_row_acc = c_row_acc;
        if (emit) begin
            n_tgt_col = c_tgt_col + TC_W'(1);
            n_col_acc = sat_add(c_col_acc, r_x_step);
        end
        if (col_end) begin
            n_src_col = '0;
            n_tgt_col = '0;
            n_col_acc = '0;
            if (row_sel) begin
                n_tgt_row = c_tgt_row + TC_W'(1);
                n_row_acc = sat_add(c_row_acc, r_y_step);
            end
            if (row_end) begin
                n_src_row = '0;
                n_tgt_row = '0;
                n_row_acc = '0;
            end else begin
                n_src_row = c_src_row + SC_W'(1);
            end
        end else begin
            n_src_col = c_src_col + SC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
            r_x_step     <= RST_X_STEP;
            r_y_step     <= RST_Y_STEP;
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_tgt_col    <= '0;
            r_tgt_row    <= '0;
            r_col_acc    <= '0;
            r_row_acc    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[DIM_REG_W-1:0];
                    CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[DIM_REG_W-1:0];
                    CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DIM_REG_W-1:0];
                    CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DIM_REG_W-1:0];
                    CFG_X_STEP:     r_x_step     <= i_cfg_data[STEP_W-1:0];
                    CFG_Y_STEP:     r_y_step     <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_src_col <= n_src_col;
                r_src_row <= n_src_row;
                r_tgt_col <= n_tgt_col;
                r_tgt_row <= n_tgt_row;
                r_col_acc <= n_col_acc;
                r_row_acc <= n_row_acc;
            end
        end
    end

endmodule

// ===== rtl/nnd_queue.sv =====
// ----------------------------------------------------------------------------
// nnd_queue
// Short FIFO of picked words between the front and the back.
// ----------------------------------------------------------------------------
module nnd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nnd_pkg::t_out_word i_word,
    input  logic               i_pop,
    output nnd_pkg::t_out_word o_head,
    output nnd_pkg::t_q_status o_status
);
    import nnd_pkg::*;

    t_out_word          r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push, do_pop;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    assign o_status.full  = r_count == Q_CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/nnd_back.sv =====
// ----------------------------------------------------------------------------
// nnd_back
// Output register: drains the queue and presents one word at a time.
// ----------------------------------------------------------------------------
module nnd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nnd_pkg::t_out_word i_head,
    input  nnd_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    output nnd_pkg::t_out_word o_word,
    input  logic               i_stall
);
    import nnd_pkg::*;

    logic      r_valid;
    t_out_word r_word;
    logic      take;

    // free to load when empty or when the held word leaves this cycle
    assign take    = !r_valid || !i_stall;
    assign o_pop   = take && !i_q_status.empty;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= !i_q_status.empty;
        end
    end

endmodule

// ===== rtl/nearest_neighbour_downscaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbour_downscaler
// Path: a picked source pixel is written into the queue, then loaded into the
//   output register, from which it shows on the output.
// Throughput: one source word per cycle while the queue is not full, as the
//   front updates counters and accumulators per accepted word; at most one target word per source word.
// Reset: synchronous, active low; registers take their power-up values and
//   all counters, the queue and the output register clear.
// ----------------------------------------------------------------------------
module nearest_neighbour_downscaler #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [nnd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nnd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // source pixel stream
    input  logic                          i_in_valid,
    input  nnd_pkg::t_in_word             i_in,
    output logic                          o_in_stall,
    // target pixel stream
    output logic                          o_out_valid,
    output nnd_pkg::t_out_word            o_out,
    input  logic                          i_out_stall
);
    import nnd_pkg::*;

    // Front: classify each source word against the running target grid.
    // Only words that land on a target pixel are pushed; the rest are dropped
    // after advancing the counters.
    logic      push;
    t_out_word push_word;

    // Queue status, shared by both sides, and the head word for the back
    t_q_status q_status;
    t_out_word q_head;
    logic      pop;

    nnd_front #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_in_valid),
        .i_word    (i_in),
        .o_stall   (o_in_stall),
        .i_q_status(q_status),
        .o_push    (push),
        .o_word    (push_word)
    );

    // Queue: decouple the source side from output back-pressure. The front
    // holds off only when the queue is full, so a word waiting at the output
    // does not stop the source stream.
    nnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_status(q_status)
    );

    // Back: registered output stage; hold the word while stalled.
    nnd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_status(q_status),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .o_word    (o_out),
        .i_stall   (i_out_stall)
    );

endmodule

// ===== rtl/nnd_checker.sv =====
// ----------------------------------------------------------------------------
// nnd_checker
// Port-level checks for the nearest-neighbour downscaler.
// ----------------------------------------------------------------------------
module nnd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input nnd_pkg::t_out_word            o_out,
    input logic                          i_out_stall
);
    import nnd_pkg::*;

    // held word stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output word changed while stalled");

    // a new output word is preceded by an accepted source word
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("output word without an accepted source word");

    // reset empties the output stage
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset empties the queue, so the source side is open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind nearest_neighbour_downscaler nnd_checker u_nnd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .o_out      (o_out),
    .i_out_stall(i_out_stall)
);
